// File: hdl/sfm_pkg.sv
// ----------------------------------------------------------------------------
// sfm_pkg: shared types and constants for the stack frame manager
// Frame record, cell control, operation and status codes, stream widths.
// ----------------------------------------------------------------------------
`default_nettype none

package sfm_pkg;

    // Sizing
    localparam int MAX_FRAMES = 16;
    localparam int ADDR_W     = 32;
    localparam int DEPTH_W    = $clog2(MAX_FRAMES + 1);

    localparam logic [DEPTH_W-1:0] DEPTH_FULL  = DEPTH_W'(MAX_FRAMES);
    localparam logic [DEPTH_W-1:0] DEPTH_EMPTY = '0;

    // Stream widths: fields packed from bit 0, rounded up to whole bytes
    localparam int IN_BITS  = 2 + 2 * ADDR_W;
    localparam int OUT_BITS = 1 + 1 + 4 * ADDR_W + 2;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic CFG_SPM_BASE = 1'b0;
    localparam logic CFG_MEM_BASE = 1'b1;

    typedef enum logic [1:0] {
        OP_EVICT   = 2'd0,
        OP_RESTORE = 2'd1,
        OP_L2G     = 2'd2,
        OP_G2L     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    localparam logic DIR_SPM2MEM = 1'b0;
    localparam logic DIR_MEM2SPM = 1'b1;

    // One evicted frame
    typedef struct packed {
        logic [ADDR_W-1:0] spm_start;
        logic [ADDR_W-1:0] mem_start;
        logic [ADDR_W-1:0] size;
    } t_frame;

    // Shift control shared by every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: hdl/sfm_cell.sv
// ----------------------------------------------------------------------------
// sfm_cell: one slot of the frame stack
// Takes the upper neighbour's frame on a push, the lower one's on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module sfm_cell (
    input  wire               i_clk,
    input  sfm_pkg::t_cell_ctl i_ctl,
    input  sfm_pkg::t_frame   i_from_up,
    input  sfm_pkg::t_frame   i_from_down,
    output sfm_pkg::t_frame   o_frame
);
    import sfm_pkg::*;

    t_frame r_frame;

    // Shift the stack one place down on push, one place up on pop, else hold
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_frame <= i_from_up;
        end else if (i_ctl.pop) begin
            r_frame <= i_from_down;
        end
    end

    assign o_frame = r_frame;

endmodule

`default_nettype wire

// File: hdl/spm_stack_frame_manager_top.sv
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output is not back-pressured; the frame stack is a chain of cells whose
// top cell is the only one read, and a push or pop shifts the whole chain.
// Reset (synchronous, active low) clears the depth, both base registers and
// the output valid; frame cells are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// spm_stack_frame_manager_top: scratchpad stack frame manager
// Evicts and restores stack frames and translates addresses in the top frame.
// ----------------------------------------------------------------------------
`default_nettype none

module spm_stack_frame_manager_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // Configuration write port
    input  wire                         i_cfg_wr_en,
    input  wire                         i_cfg_index,
    input  wire [sfm_pkg::ADDR_W-1:0]   i_cfg_wdata,
    // Input stream
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: op[1:0], stack_ptr[33:2], addr[65:34], zero fill
    input  wire [sfm_pkg::IN_W-1:0]     s_axis_tdata,
    // Output stream
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    // tdata: dma_valid[0], dma_dir[1], dma_spm_addr[33:2], dma_mem_addr[65:34],
    //        dma_size[97:66], xlat_addr[129:98], status[131:130], zero fill
    output logic [sfm_pkg::OUT_W-1:0]   m_axis_tdata
);
    import sfm_pkg::*;

    // Configuration
    logic [ADDR_W-1:0] r_spm_base;
    logic [ADDR_W-1:0] r_mem_base;

    // Stack control
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] n_depth;

    // Output register
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic [OUT_W-1:0]   n_out_data;

    // Unpacked input word
    t_op               w_op;
    logic [ADDR_W-1:0] w_sp;
    logic [ADDR_W-1:0] w_addr;
    logic              w_accept;

    // Chain
    t_cell_ctl w_ctl;
    t_frame    w_new_frame;
    t_frame    w_frame [MAX_FRAMES];

    // Datapath
    logic              w_empty;
    logic              w_full;
    logic [ADDR_W-1:0] w_top;
    logic [ADDR_W-1:0] w_size;
    logic [ADDR_W-1:0] w_low;
    logic [ADDR_W-1:0] w_l2g;
    logic [ADDR_W-1:0] w_g2l;

    logic              n_dma_valid;
    logic              n_dma_dir;
    logic [ADDR_W-1:0] n_dma_spm;
    logic [ADDR_W-1:0] n_dma_mem;
    logic [ADDR_W-1:0] n_dma_size;
    logic [ADDR_W-1:0] n_xlat;
    t_status           n_status;

    assign w_op     = t_op'(s_axis_tdata[1:0]);
    assign w_sp     = s_axis_tdata[ADDR_W+1:2];
    assign w_addr   = s_axis_tdata[2*ADDR_W+1:ADDR_W+2];

    // Take a word whenever the output register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Hold the base registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm_base <= '0;
            r_mem_base <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_SPM_BASE) begin
                r_spm_base <= i_cfg_wdata;
            end
            if (i_cfg_index == CFG_MEM_BASE) begin
                r_mem_base <= i_cfg_wdata;
            end
        end
    end

    // Frame arithmetic from the top cell
    assign w_empty = (r_depth == DEPTH_EMPTY);
    assign w_full  = (r_depth == DEPTH_FULL);
    assign w_top   = w_empty ? r_mem_base : w_frame[0].mem_start;
    assign w_size  = r_spm_base - w_sp;
    assign w_low   = w_top - w_size;
    assign w_l2g   = w_top - (r_spm_base - w_addr);
    assign w_g2l   = r_spm_base - (w_top - w_addr);

    assign w_new_frame.spm_start = w_sp;
    assign w_new_frame.mem_start = w_low;
    assign w_new_frame.size      = w_size;

    // Decode the operation into a result and a chain shift
    always_comb begin
        n_dma_valid = 1'b0;
        n_dma_dir   = DIR_SPM2MEM;
        n_dma_spm   = '0;
        n_dma_mem   = '0;
        n_dma_size  = '0;
        n_xlat      = '0;
        n_status    = ST_OK;
        w_ctl.push  = 1'b0;
        w_ctl.pop   = 1'b0;
        n_depth     = r_depth;
        case (w_op)
            OP_EVICT: begin
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_dma_valid = 1'b1;
                    n_dma_spm   = w_sp;
                    n_dma_mem   = w_low;
                    n_dma_size  = w_size;
                    w_ctl.push  = w_accept;
                    n_depth     = r_depth + 1'b1;
                end
            end
            OP_RESTORE: begin
                if (w_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_dma_valid = 1'b1;
                    n_dma_dir   = DIR_MEM2SPM;
                    n_dma_spm   = w_frame[0].spm_start;
                    n_dma_mem   = w_frame[0].mem_start;
                    n_dma_size  = w_frame[0].size;
                    w_ctl.pop   = w_accept;
                    n_depth     = r_depth - 1'b1;
                end
            end
            OP_L2G: begin
                n_xlat = (w_addr >= w_sp && w_addr < r_spm_base) ? w_l2g : w_addr;
            end
            OP_G2L: begin
                n_xlat = (w_addr >= w_low && w_addr < w_top) ? w_g2l : w_addr;
            end
            default: begin
                n_xlat = w_addr;
            end
        endcase
    end

    // Build the chain; cell 0 is the top of the stack
    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        t_frame w_up;
        t_frame w_down;
        if (g == 0) begin : g_head
            assign w_up = w_new_frame;
        end else begin : g_body
            assign w_up = w_frame[g-1];
        end
        if (g == MAX_FRAMES - 1) begin : g_tail
            assign w_down = w_frame[g];
        end else begin : g_link
            assign w_down = w_frame[g+1];
        end
        sfm_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_frame     (w_frame[g])
        );
    end

    // Advance the depth on an accepted push or pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_EMPTY;
        end else if (w_accept) begin
            r_depth <= n_depth;
        end
    end

    assign n_out_data = {{(OUT_W - OUT_BITS){1'b0}}, n_status, n_xlat, n_dma_size,
                         n_dma_mem, n_dma_spm, n_dma_dir, n_dma_valid};

    // Output register: load on accept, drop valid once drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // Depth never exceeds the number of cells
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_FULL)
        else $error("frame depth above capacity");

    // A successful evict grows the stack by exactly one
    a_push_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_EVICT && !w_full) |=> (r_depth == $past(r_depth) + 1'b1))
        else $error("evict did not push");

    // Depth moves only with an accepted word
    a_depth_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_depth))
        else $error("depth changed without an accepted word");

    // A flagged error never requests a transfer
    a_err_no_dma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[OUT_BITS-1:OUT_BITS-2] != ST_OK) |-> !r_out_data[0])
        else $error("transfer requested alongside error status");
`endif

endmodule

`default_nettype wire
